FILE: hdl/bsss_pkg.sv
// Shared types, codes and defaults for the bounded stack sort and search unit.
package bsss_pkg;

   // Default number of stack entries.
   localparam int DEPTH_DEFAULT = 16;

   // Width of the value and data fields.
   localparam int DATA_W = 32;

   // Width of the reported index; positions wrap modulo sixteen.
   localparam int INDEX_W = 4;

   // Command codes carried by an input beat.
   typedef enum logic [2:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_DUMP   = 3'd2,
      CMD_SORT   = 3'd3,
      CMD_SEARCH = 3'd4
   } cmd_type;

   // Status codes carried by a result beat.
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_MISS  = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_DUMP,
      S_SRCH,
      S_SORT_LDA,
      S_SORT_CMP,
      S_SORT_WRA
   } state_type;

   // Input beat.
   typedef struct packed {
      logic [2:0]               cmd;
      logic signed [DATA_W-1:0] value;
   } req_type;

   // Result beat.
   typedef struct packed {
      status_type               status;
      logic [INDEX_W-1:0]       index;
      logic signed [DATA_W-1:0] data;
      logic                     last;
   } rsp_type;

endpackage

FILE: hdl/bsss_mem.sv
// Entry store: one write port and one registered read port.
module bsss_mem #(
   parameter int DEPTH = bsss_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [bsss_pkg::DATA_W-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [bsss_pkg::DATA_W-1:0] rd_data
);

   logic [bsss_pkg::DATA_W-1:0] mem [DEPTH];
   logic [bsss_pkg::DATA_W-1:0] rd_data_ff;

   // Write and registered read; contents are undefined until written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bsss_seq.sv
// Sequencer with the shared comparator that walks the entry store.
module bsss_seq #(
   parameter int DEPTH = bsss_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  bsss_pkg::req_type           req_item,
   output logic                        rsp_valid,
   output bsss_pkg::rsp_type           rsp_item,
   output logic                        mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]    mem_wr_addr,
   output logic [bsss_pkg::DATA_W-1:0] mem_wr_data,
   output logic [$clog2(DEPTH)-1:0]    mem_rd_addr,
   input  logic [bsss_pkg::DATA_W-1:0] mem_rd_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EXT_W = IDX_W + bsss_pkg::INDEX_W;

   bsss_pkg::state_type         state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            pos_ff, pos_in;
   logic [IDX_W-1:0]            jpos_ff, jpos_in;
   logic [bsss_pkg::DATA_W-1:0] a_ff, a_in;
   logic [bsss_pkg::DATA_W-1:0] key_ff, key_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   bsss_pkg::rsp_type           rsp_ff, rsp_in;

   logic                        accept;
   logic                        is_empty;
   logic                        is_full;
   logic                        gt;
   logic                        eq;
   logic [CNT_W-1:0]            pos_p1;
   logic [CNT_W-1:0]            pos_p2;
   logic [CNT_W-1:0]            jpos_p1;
   logic [CNT_W-1:0]            count_m1;
   logic [EXT_W-1:0]            pos_ext;
   logic [EXT_W-1:0]            top_ext;

   assign accept   = start && (state_ff == bsss_pkg::S_IDLE);
   assign busy     = (state_ff != bsss_pkg::S_IDLE);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(DEPTH));

   // Shared comparator: the store's read data against the held operand.
   assign gt = ($signed(a_ff) > $signed(mem_rd_data));
   assign eq = (mem_rd_data == key_ff);

   // Position arithmetic; every sum stays within the entry count.
   assign pos_p1   = CNT_W'(pos_ff) + CNT_W'(1);
   assign pos_p2   = CNT_W'(pos_ff) + CNT_W'(2);
   assign jpos_p1  = CNT_W'(jpos_ff) + CNT_W'(1);
   assign count_m1 = count_ff - CNT_W'(1);

   // Reported positions wrap to the index field width.
   assign pos_ext = EXT_W'(pos_ff);
   assign top_ext = EXT_W'(count_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsss_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      jpos_ff <= jpos_in;
      a_ff    <= a_in;
      key_ff  <= key_in;
      rsp_ff  <= rsp_in;
   end

   // Next state, store accesses and the result beat.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      jpos_in      = jpos_ff;
      a_in         = a_ff;
      key_in       = key_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = pos_ff;
      mem_wr_data  = a_ff;
      mem_rd_addr  = pos_ff;
      rsp_valid_in = 1'b0;
      rsp_in.status = bsss_pkg::STAT_OK;
      rsp_in.index  = '0;
      rsp_in.data   = '0;
      rsp_in.last   = 1'b1;

      case (state_ff)
         bsss_pkg::S_IDLE: begin
            if (accept) begin
               case (req_item.cmd)
                  bsss_pkg::CMD_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_in.status = bsss_pkg::STAT_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = IDX_W'(count_ff);
                        mem_wr_data = req_item.value;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  bsss_pkg::CMD_POP: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = bsss_pkg::STAT_EMPTY;
                     end else begin
                        mem_rd_addr = IDX_W'(count_m1);
                        count_in    = count_m1;
                        state_in    = bsss_pkg::S_POP;
                     end
                  end
                  bsss_pkg::CMD_DUMP: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = bsss_pkg::STAT_EMPTY;
                     end else begin
                        mem_rd_addr = '0;
                        pos_in      = '0;
                        state_in    = bsss_pkg::S_DUMP;
                     end
                  end
                  bsss_pkg::CMD_SORT: begin
                     if (count_ff < CNT_W'(2)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        mem_rd_addr = '0;
                        pos_in      = '0;
                        state_in    = bsss_pkg::S_SORT_LDA;
                     end
                  end
                  bsss_pkg::CMD_SEARCH: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = bsss_pkg::STAT_MISS;
                     end else begin
                        key_in      = req_item.value;
                        mem_rd_addr = '0;
                        pos_in      = '0;
                        state_in    = bsss_pkg::S_SRCH;
                     end
                  end
                  default: begin
                     // Undefined command codes leave everything untouched.
                     state_in = bsss_pkg::S_IDLE;
                  end
               endcase
            end
         end

         // The top entry arrives from the store; count already points at it.
         bsss_pkg::S_POP: begin
            rsp_valid_in = 1'b1;
            rsp_in.index = top_ext[bsss_pkg::INDEX_W-1:0];
            rsp_in.data  = mem_rd_data;
            state_in     = bsss_pkg::S_IDLE;
         end

         // One entry per cycle from the bottom up, with the next read in flight.
         bsss_pkg::S_DUMP: begin
            rsp_valid_in = 1'b1;
            rsp_in.index = pos_ext[bsss_pkg::INDEX_W-1:0];
            rsp_in.data  = mem_rd_data;
            if (pos_p1 == count_ff) begin
               state_in = bsss_pkg::S_IDLE;
            end else begin
               rsp_in.last = 1'b0;
               mem_rd_addr = IDX_W'(pos_p1);
               pos_in      = IDX_W'(pos_p1);
            end
         end

         // Linear search stops at the first equal entry.
         bsss_pkg::S_SRCH: begin
            if (eq) begin
               rsp_valid_in = 1'b1;
               rsp_in.index = pos_ext[bsss_pkg::INDEX_W-1:0];
               rsp_in.data  = mem_rd_data;
               state_in     = bsss_pkg::S_IDLE;
            end else if (pos_p1 == count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = bsss_pkg::STAT_MISS;
               state_in      = bsss_pkg::S_IDLE;
            end else begin
               mem_rd_addr = IDX_W'(pos_p1);
               pos_in      = IDX_W'(pos_p1);
            end
         end

         // Hold entry i in a register and start reading entry i + 1.
         bsss_pkg::S_SORT_LDA: begin
            a_in        = mem_rd_data;
            jpos_in     = IDX_W'(pos_p1);
            mem_rd_addr = IDX_W'(pos_p1);
            state_in    = bsss_pkg::S_SORT_CMP;
         end

         // Compare entry j with the held entry i; on a swap the old entry i
         // goes to j and entry j becomes the held value.
         bsss_pkg::S_SORT_CMP: begin
            if (gt) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = jpos_ff;
               mem_wr_data = a_ff;
               a_in        = mem_rd_data;
            end
            if (jpos_p1 == count_ff) begin
               state_in = bsss_pkg::S_SORT_WRA;
            end else begin
               mem_rd_addr = IDX_W'(jpos_p1);
               jpos_in     = IDX_W'(jpos_p1);
            end
         end

         // Write the settled minimum back to position i and move on.
         bsss_pkg::S_SORT_WRA: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_ff;
            mem_wr_data = a_ff;
            if (pos_p2 == count_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = bsss_pkg::S_IDLE;
            end else begin
               mem_rd_addr = IDX_W'(pos_p1);
               pos_in      = IDX_W'(pos_p1);
               state_in    = bsss_pkg::S_SORT_LDA;
            end
         end

         default: begin
            state_in = bsss_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

FILE: hdl/bounded_stack_sort_search_unit.sv
// Top level of the bounded stack with exchange sort and linear search.
//
// A command beat is taken when start is high and busy is low; busy then stays
// high until the sequencer is done, and each result beat shows on rsp_item for
// exactly one cycle with rsp_valid high, in the cycle after the sequencer
// decides it. The receiver cannot stall, so a dump streams one beat per cycle.
// A push or an undefined code never raises busy. The length of each busy
// stretch is set by the single read port of the entry store and the one
// shared comparator, which see one entry per cycle.
module bounded_stack_sort_search_unit #(
   parameter int DEPTH = bsss_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bsss_pkg::req_type req_item,
   output logic              rsp_valid,
   output bsss_pkg::rsp_type rsp_item
);

   localparam int IDX_W = $clog2(DEPTH);

   logic                        mem_wr_en;
   logic [IDX_W-1:0]            mem_wr_addr;
   logic [bsss_pkg::DATA_W-1:0] mem_wr_data;
   logic [IDX_W-1:0]            mem_rd_addr;
   logic [bsss_pkg::DATA_W-1:0] mem_rd_data;

   // Sequencer and shared comparator.
   bsss_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // Entry store.
   bsss_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

FILE: tb/sv/tb_bounded_stack_sort_search_unit.sv
// Self-checking testbench for the bounded stack sort and search unit.
`timescale 1ns / 1ps

module tb_bounded_stack_sort_search_unit;

   localparam int STACK_DEPTH   = bsss_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 500;
   // The longest busy stretch is a full sort.
   localparam int SETTLE_CYCLES = 200;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 40;

   // Codes outside the command set; the unit must ignore them.
   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

   typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} traffic_mode_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   bsss_pkg::req_type req_item;
   logic              rsp_valid;
   bsss_pkg::rsp_type rsp_item;

   // Shadow copy of the stack and the replies it still owes.
   logic signed [bsss_pkg::DATA_W-1:0] shadow_entries [STACK_DEPTH];
   int                                 shadow_count;
   bsss_pkg::rsp_type                  stack_replies[$];

   bit steady_stream;
   int error_count;
   int beats_checked;
   int cmd_hits [8];
   int full_pushes;
   int empty_hits;
   int stall_cycles;

   bounded_stack_sort_search_unit #(
      .DEPTH(STACK_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bsss_pkg::rsp_type reply(bsss_pkg::status_type st, int idx,
                                               logic signed [bsss_pkg::DATA_W-1:0] d,
                                               logic lst);
      bsss_pkg::rsp_type r;
      r.status = st;
      r.index  = idx[bsss_pkg::INDEX_W-1:0];
      r.data   = d;
      r.last   = lst;
      return r;
   endfunction

   // Apply one command to the shadow stack and queue the beats it causes.
   function automatic void apply_stack_command(logic [2:0] cmd,
                                               logic signed [bsss_pkg::DATA_W-1:0] value);
      int                                 i;
      int                                 j;
      bit                                 found;
      logic signed [bsss_pkg::DATA_W-1:0] swap;
      found = 1'b0;
      case (cmd)
         bsss_pkg::CMD_PUSH: begin
            if (shadow_count >= STACK_DEPTH) begin
               stack_replies.push_back(reply(bsss_pkg::STAT_FULL, 0, '0, 1'b1));
               full_pushes++;
            end else begin
               shadow_entries[shadow_count] = value;
               shadow_count++;
               stack_replies.push_back(reply(bsss_pkg::STAT_OK, 0, '0, 1'b1));
            end
         end
         bsss_pkg::CMD_POP: begin
            if (shadow_count == 0) begin
               stack_replies.push_back(reply(bsss_pkg::STAT_EMPTY, 0, '0, 1'b1));
               empty_hits++;
            end else begin
               shadow_count--;
               stack_replies.push_back(reply(bsss_pkg::STAT_OK, shadow_count,
                                             shadow_entries[shadow_count], 1'b1));
            end
         end
         bsss_pkg::CMD_DUMP: begin
            if (shadow_count == 0) begin
               stack_replies.push_back(reply(bsss_pkg::STAT_EMPTY, 0, '0, 1'b1));
               empty_hits++;
            end
            for (i = 0; i < shadow_count; i++)
               stack_replies.push_back(reply(bsss_pkg::STAT_OK, i, shadow_entries[i],
                                             i + 1 == shadow_count));
         end
         bsss_pkg::CMD_SORT: begin
            // Exchange sort in signed order, the same walk the hardware makes.
            for (i = 0; i + 1 < shadow_count; i++) begin
               for (j = i + 1; j < shadow_count; j++) begin
                  if (shadow_entries[i] > shadow_entries[j]) begin
                     swap              = shadow_entries[i];
                     shadow_entries[i] = shadow_entries[j];
                     shadow_entries[j] = swap;
                  end
               end
            end
            stack_replies.push_back(reply(bsss_pkg::STAT_OK, 0, '0, 1'b1));
         end
         bsss_pkg::CMD_SEARCH: begin
            // The lowest matching position wins.
            for (i = 0; i < shadow_count && !found; i++) begin
               if (shadow_entries[i] == value) begin
                  stack_replies.push_back(reply(bsss_pkg::STAT_OK, i, shadow_entries[i],
                                                1'b1));
                  found = 1'b1;
               end
            end
            if (!found)
               stack_replies.push_back(reply(bsss_pkg::STAT_MISS, 0, '0, 1'b1));
         end
         default: begin
         end
      endcase
   endfunction

   function automatic logic signed [bsss_pkg::DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 4))
            0: return {1'b1, {(bsss_pkg::DATA_W-1){1'b0}}};
            1: return {1'b0, {(bsss_pkg::DATA_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return 1;
         endcase
      end
      // A narrow range makes duplicates, which searches and sorts need.
      if (r < 40)
         return $signed($urandom_range(0, 16)) - 8;
      return $urandom;
   endfunction

   // Search keys hit a stored entry about half the time.
   function automatic logic signed [bsss_pkg::DATA_W-1:0] pick_key();
      if (shadow_count > 0 && $urandom_range(0, 1) == 1)
         return shadow_entries[$urandom_range(0, shadow_count - 1)];
      return pick_value();
   endfunction

   function automatic logic [2:0] pick_cmd(traffic_mode_type mode);
      int r;
      int push_pct;
      int pop_pct;
      r        = $urandom_range(0, 99);
      push_pct = (mode == MODE_GROW) ? 55 : (mode == MODE_SHRINK) ? 15 : 35;
      pop_pct  = (mode == MODE_SHRINK) ? 45 : (mode == MODE_GROW) ? 10 : 25;
      if (r < push_pct)
         return bsss_pkg::CMD_PUSH;
      if (r < push_pct + pop_pct)
         return bsss_pkg::CMD_POP;
      if (r < push_pct + pop_pct + 8)
         return bsss_pkg::CMD_DUMP;
      if (r < push_pct + pop_pct + 15)
         return bsss_pkg::CMD_SORT;
      if (r < 96)
         return bsss_pkg::CMD_SEARCH;
      return 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
   endfunction

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (steady_stream)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Lower start for a number of cycles; zero keeps it high for the next beat.
   task automatic pause(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Offer one command beat and hold it until the unit takes it.
   task automatic send_cmd(logic [2:0] cmd, logic signed [bsss_pkg::DATA_W-1:0] value);
      @(negedge clock);
      start    <= 1'b1;
      req_item <= '{cmd: cmd, value: value};
      do @(posedge clock); while (busy !== 1'b0);
      apply_stack_command(cmd, value);
      cmd_hits[cmd]++;
      pause(pick_gap());
   endtask

   // Hold off the sender until every owed beat has come back.
   task automatic drain();
      pause(1);
      while (stack_replies.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(string field, longint want, longint got);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
   endtask

   // Empty-stack replies, ignored codes, extreme values, duplicates and a small sort.
   task automatic test_empty_and_extremes();
      logic [2:0] code;
      send_cmd(bsss_pkg::CMD_POP, pick_value());
      send_cmd(bsss_pkg::CMD_DUMP, pick_value());
      send_cmd(bsss_pkg::CMD_SORT, pick_value());
      send_cmd(bsss_pkg::CMD_SEARCH, '0);
      for (code = CMD_UNUSED_FIRST; code != bsss_pkg::CMD_PUSH; code++)
         send_cmd(code, pick_value());
      send_cmd(bsss_pkg::CMD_PUSH, {1'b0, {(bsss_pkg::DATA_W-1){1'b1}}});
      send_cmd(bsss_pkg::CMD_SORT, '0);
      send_cmd(bsss_pkg::CMD_PUSH, {1'b1, {(bsss_pkg::DATA_W-1){1'b0}}});
      send_cmd(bsss_pkg::CMD_PUSH, '0);
      send_cmd(bsss_pkg::CMD_PUSH, '1);
      send_cmd(bsss_pkg::CMD_PUSH, {1'b0, {(bsss_pkg::DATA_W-1){1'b1}}});
      send_cmd(bsss_pkg::CMD_SEARCH, {1'b0, {(bsss_pkg::DATA_W-1){1'b1}}});
      send_cmd(bsss_pkg::CMD_SEARCH, {1'b1, {(bsss_pkg::DATA_W-1){1'b0}}});
      send_cmd(bsss_pkg::CMD_SEARCH, 32'sd123456);
      send_cmd(bsss_pkg::CMD_DUMP, '0);
      send_cmd(bsss_pkg::CMD_SORT, '0);
      send_cmd(bsss_pkg::CMD_DUMP, '0);
      send_cmd(bsss_pkg::CMD_SEARCH, '1);
      send_cmd(bsss_pkg::CMD_POP, '0);
      send_cmd(bsss_pkg::CMD_POP, '0);
   endtask

   // Fill to capacity, push past it, sort and dump a full stack, then pop it dry.
   task automatic test_fill_and_overflow();
      while (shadow_count < STACK_DEPTH)
         send_cmd(bsss_pkg::CMD_PUSH, pick_value());
      send_cmd(bsss_pkg::CMD_PUSH, pick_value());
      send_cmd(bsss_pkg::CMD_PUSH, pick_value());
      send_cmd(bsss_pkg::CMD_SEARCH, shadow_entries[STACK_DEPTH - 1]);
      send_cmd(bsss_pkg::CMD_SORT, pick_value());
      send_cmd(bsss_pkg::CMD_DUMP, pick_value());
      send_cmd(bsss_pkg::CMD_SEARCH, shadow_entries[STACK_DEPTH - 1]);
      while (shadow_count > 0)
         send_cmd(bsss_pkg::CMD_POP, pick_value());
      send_cmd(bsss_pkg::CMD_POP, pick_value());
   endtask

   // Runs of growing, shrinking and mixed traffic with random content.
   task automatic test_random_traffic();
      int               counted;
      int               run_len;
      int               k;
      traffic_mode_type mode;
      logic [2:0]       cmd;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         mode          = traffic_mode_type'($urandom_range(0, 2));
         steady_stream = ($urandom_range(0, 3) == 0);
         run_len       = $urandom_range(15, 50);
         for (k = 0; k < run_len; k++) begin
            cmd = pick_cmd(mode);
            send_cmd(cmd, (cmd == bsss_pkg::CMD_SEARCH) ? pick_key() : pick_value());
            if (cmd < CMD_UNUSED_FIRST)
               counted++;
         end
         if ($urandom_range(0, 4) == 0)
            drain();
      end
      steady_stream = 1'b0;
   endtask

   // Compare each result beat with the oldest owed reply.
   always @(posedge clock) begin
      bsss_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (stack_replies.size() == 0) begin
            error_count++;
            $error("result beat with no reply owed: status %0d index %0d data %0d last %0d",
                   rsp_item.status, rsp_item.index, rsp_item.data, rsp_item.last);
         end else begin
            want = stack_replies.pop_front();
            beats_checked++;
            if (rsp_item.status !== want.status)
               report_mismatch("status", want.status, rsp_item.status);
            if (rsp_item.index !== want.index)
               report_mismatch("index", want.index, rsp_item.index);
            if (rsp_item.data !== want.data)
               report_mismatch("data", want.data, rsp_item.data);
            if (rsp_item.last !== want.last)
               report_mismatch("last", want.last, rsp_item.last);
         end
      end
   end

   // Watchdog on cycles in which no beat moves in either direction.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_item      = '0;
      shadow_count  = 0;
      steady_stream = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_empty_and_extremes();
      drain();
      test_fill_and_overflow();
      drain();
      test_random_traffic();

      // Wait out the owed replies, then watch for stray beats.
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Commands sent: %0d push, %0d pop, %0d dump, %0d sort, %0d search, %0d ignored.",
               cmd_hits[bsss_pkg::CMD_PUSH], cmd_hits[bsss_pkg::CMD_POP],
               cmd_hits[bsss_pkg::CMD_DUMP], cmd_hits[bsss_pkg::CMD_SORT],
               cmd_hits[bsss_pkg::CMD_SEARCH], cmd_hits[5] + cmd_hits[6] + cmd_hits[7]);
      $display("Result beats checked: %0d, pushes on a full stack: %0d, empty replies: %0d.",
               beats_checked, full_pushes, empty_hits);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: bounded_stack_sort_search_unit.f
hdl/bsss_pkg.sv
hdl/bsss_mem.sv
hdl/bsss_seq.sv
hdl/bounded_stack_sort_search_unit.sv
tb/sv/tb_bounded_stack_sort_search_unit.sv
